[sv/srp_pkg.sv]
// Shared types, constants and codes for the shelf rectangle packer.
// Used by srp_fit_unit, shelf_rect_packer and tb_top; depends on nothing else.
package srp_pkg;

    // Field and register widths
    localparam int unsigned SRP_DIM_W     = 13;
    localparam int unsigned SRP_POS_W     = 12;
    localparam int unsigned SRP_STATUS_W  = 2;
    localparam int unsigned SRP_X_W       = 14;
    localparam int unsigned SRP_SUM_W     = 15;
    localparam int unsigned SRP_MAX_SHELVES = 64;

    // Padding added to each side length of a request
    localparam logic [SRP_X_W-1:0] SRP_PAD = 14'd2;

    // Reset value of both atlas size registers
    localparam logic [SRP_DIM_W-1:0] SRP_ATLAS_RESET = 13'd1024;

    // Configuration register indexes
    localparam logic SRP_REG_ATLAS_WIDTH  = 1'b0;
    localparam logic SRP_REG_ATLAS_HEIGHT = 1'b1;

    // Result status codes
    typedef enum logic [SRP_STATUS_W-1:0] {
        SRP_ST_PLACED      = 2'd0,
        SRP_ST_HEIGHT_FULL = 2'd1,
        SRP_ST_TABLE_FULL  = 2'd2
    } srp_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        SRP_IDLE,
        SRP_SCAN,
        SRP_NEW_SHELF,
        SRP_DONE
    } srp_state_t;

    // One shelf table entry
    typedef struct packed {
        logic [SRP_X_W-1:0]   next_x;
        logic [SRP_DIM_W-1:0] top_y;
        logic [SRP_DIM_W-1:0] height;
    } srp_shelf_t;

    // Operands of the shared add and compare unit
    typedef struct packed {
        logic [SRP_X_W-1:0]   base;
        logic [SRP_X_W-1:0]   size;
        logic [SRP_DIM_W-1:0] limit;
        logic                 chk_h;
        logic [SRP_X_W-1:0]   req_h;
        logic [SRP_DIM_W-1:0] shelf_h;
    } srp_op_t;

    // Result of the shared unit
    typedef struct packed {
        logic [SRP_SUM_W-1:0] sum;
        logic                 fits;
    } srp_res_t;

endpackage

[sv/srp_fit_unit.sv]
// Shared add and compare unit of the shelf rectangle packer.
// Depends on srp_pkg for the operand and result structs.
module srp_fit_unit
    import srp_pkg::*;
(
    input  srp_op_t  op,
    output srp_res_t res
);

    logic [SRP_SUM_W-1:0] sum;
    logic                 fits_len;
    logic                 fits_h;

    // Base plus size must stay within the limit; optionally the request must
    // be no taller than the shelf.
    assign sum      = SRP_SUM_W'(op.base) + SRP_SUM_W'(op.size);
    assign fits_len = (sum <= SRP_SUM_W'(op.limit));
    assign fits_h   = (op.req_h <= SRP_X_W'(op.shelf_h));

    assign res.sum  = sum;
    assign res.fits = fits_len && (!op.chk_h || fits_h);

endmodule

[sv/shelf_rect_packer.sv]
// Top level of the shelf rectangle packer: sequencer, shelf table memory and
// output register. Depends on srp_pkg and srp_fit_unit.
//
//  Channel  Ports              Payload (low bit first)
//  -------  -----------------  ----------------------------------------------
//  request  s_tvalid/s_tready  s_tdata: rect_width[12:0], rect_height[25:13]
//  result   m_tvalid/m_tready  m_tdata: status[1:0], pos_x[13:2], pos_y[25:14]
//  config   cfg_wr_en          cfg_index 0 atlas_width, 1 atlas_height
//
// A request scans the shelf table with one read per cycle through the single
// memory read port, each entry checked by the shared fit unit; if no shelf
// fits, a new shelf step follows, then the result register is loaded once free.
// A new request is accepted only while the sequencer is idle.
// Reset (synchronous, active low) empties the shelf table by clearing the
// shelf count; no clearing pass is needed.
// A stalled result holds in the output register until it is taken.
module shelf_rect_packer
    import srp_pkg::*;
#(
    parameter int unsigned MAX_SHELVES = SRP_MAX_SHELVES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rect_width[12:0], rect_height[25:13]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], pos_x[13:2], pos_y[25:14]
    // Configuration writes
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [SRP_DIM_W-1:0] cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_SHELVES + 1);
    localparam int unsigned AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

    // Registers
    srp_state_t            state_reg, state_next;
    logic [SRP_X_W-1:0]    pw_reg, pw_next;
    logic [SRP_X_W-1:0]    ph_reg, ph_next;
    logic [CW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                  rd_pend_reg;
    logic                  rd_last_reg;
    logic [AW-1:0]         rd_idx_reg;
    srp_shelf_t            rd_data_reg;
    logic [CW-1:0]         shelf_count_reg, shelf_count_next;
    logic [SRP_DIM_W-1:0]  bottom_reg, bottom_next;
    srp_status_t           res_status_reg, res_status_next;
    logic [SRP_POS_W-1:0]  res_x_reg, res_x_next;
    logic [SRP_POS_W-1:0]  res_y_reg, res_y_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [31:0]           m_tdata_reg, m_tdata_next;
    logic [SRP_DIM_W-1:0]  atlas_w_reg;
    logic [SRP_DIM_W-1:0]  atlas_h_reg;

    // Shelf table memory
    srp_shelf_t            mem [MAX_SHELVES];
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    srp_shelf_t            wr_data;
    logic                  issue_en;
    logic [AW-1:0]         rd_addr;
    logic                  issue_last;

    srp_op_t               op;
    srp_res_t              res;
    logic                  s_accept;

    assign s_tready = (state_reg == SRP_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Shared add and compare unit
    srp_fit_unit u_fit (
        .op  (op),
        .res (res)
    );

    // Read issue: one table entry per cycle while scanning
    assign rd_addr    = issue_cnt_reg[AW-1:0];
    assign issue_last = (CW'(issue_cnt_reg + CW'(1)) == shelf_count_reg);
    assign issue_en   = (state_reg == SRP_SCAN) && (issue_cnt_reg < shelf_count_reg)
                        && !(rd_pend_reg && res.fits);

    // Operand selection for the shared unit
    always_comb begin
        if (state_reg == SRP_SCAN) begin
            op.base    = rd_data_reg.next_x;
            op.size    = pw_reg;
            op.limit   = atlas_w_reg;
            op.chk_h   = 1'b1;
        end else begin
            op.base    = SRP_X_W'(bottom_reg);
            op.size    = ph_reg;
            op.limit   = atlas_h_reg;
            op.chk_h   = 1'b0;
        end
        op.req_h   = ph_reg;
        op.shelf_h = rd_data_reg.height;
    end

    // Sequencer: next state, table writes and result
    always_comb begin
        state_next       = state_reg;
        pw_next          = pw_reg;
        ph_next          = ph_reg;
        issue_cnt_next   = issue_cnt_reg;
        shelf_count_next = shelf_count_reg;
        bottom_next      = bottom_reg;
        res_status_next  = res_status_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        wr_addr          = rd_idx_reg;
        wr_data          = rd_data_reg;

        if (issue_en) begin
            issue_cnt_next = CW'(issue_cnt_reg + CW'(1));
        end

        case (state_reg)
            SRP_IDLE: begin
                if (s_accept) begin
                    pw_next        = SRP_X_W'(s_tdata[12:0]) + SRP_PAD;
                    ph_next        = SRP_X_W'(s_tdata[25:13]) + SRP_PAD;
                    issue_cnt_next = '0;
                    state_next     = (shelf_count_reg != '0) ? SRP_SCAN : SRP_NEW_SHELF;
                end
            end
            SRP_SCAN: begin
                if (rd_pend_reg && res.fits) begin
                    // First fit: place here and advance the shelf's x
                    mem_we          = 1'b1;
                    wr_addr         = rd_idx_reg;
                    wr_data         = rd_data_reg;
                    wr_data.next_x  = res.sum[SRP_X_W-1:0];
                    res_status_next = SRP_ST_PLACED;
                    res_x_next      = rd_data_reg.next_x[SRP_POS_W-1:0];
                    res_y_next      = rd_data_reg.top_y[SRP_POS_W-1:0];
                    state_next      = SRP_DONE;
                end else if (rd_pend_reg && rd_last_reg) begin
                    state_next = SRP_NEW_SHELF;
                end
            end
            SRP_NEW_SHELF: begin
                res_x_next = '0;
                res_y_next = '0;
                if (!res.fits) begin
                    res_status_next = SRP_ST_HEIGHT_FULL;
                end else if (shelf_count_reg >= CW'(MAX_SHELVES)) begin
                    res_status_next = SRP_ST_TABLE_FULL;
                end else begin
                    // Open a new shelf below the last one
                    mem_we           = 1'b1;
                    wr_addr          = shelf_count_reg[AW-1:0];
                    wr_data.next_x   = pw_reg;
                    wr_data.top_y    = bottom_reg;
                    wr_data.height   = ph_reg[SRP_DIM_W-1:0];
                    shelf_count_next = CW'(shelf_count_reg + CW'(1));
                    bottom_next      = res.sum[SRP_DIM_W-1:0];
                    res_status_next  = SRP_ST_PLACED;
                    res_y_next       = bottom_reg[SRP_POS_W-1:0];
                end
                state_next = SRP_DONE;
            end
            SRP_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_y_reg, res_x_reg, res_status_reg};
                    state_next    = SRP_IDLE;
                end
            end
            default: begin
                state_next = SRP_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SRP_IDLE;
            shelf_count_reg <= '0;
            bottom_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            atlas_w_reg     <= SRP_ATLAS_RESET;
            atlas_h_reg     <= SRP_ATLAS_RESET;
        end else begin
            state_reg       <= state_next;
            shelf_count_reg <= shelf_count_next;
            bottom_reg      <= bottom_next;
            rd_pend_reg     <= issue_en;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en && (cfg_index == SRP_REG_ATLAS_WIDTH)) begin
                atlas_w_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == SRP_REG_ATLAS_HEIGHT)) begin
                atlas_h_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pw_reg         <= pw_next;
        ph_reg         <= ph_next;
        issue_cnt_reg  <= issue_cnt_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        m_tdata_reg    <= m_tdata_next;
        if (issue_en) begin
            rd_idx_reg  <= rd_addr;
            rd_last_reg <= issue_last;
        end
    end

    // Shelf table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // The shelf count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        shelf_count_reg <= CW'(MAX_SHELVES))
        else $error("shelf count beyond table depth");

    // The shelf count only ever grows by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (shelf_count_reg != $past(shelf_count_reg)) |->
        (shelf_count_reg == CW'($past(shelf_count_reg) + CW'(1))))
        else $error("shelf count changed by more than one");

    // The new shelf step always ends the request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SRP_NEW_SHELF) |=> (state_reg == SRP_DONE))
        else $error("new shelf step did not finish");

    // A table write never lands beyond the shelves in use plus one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CW'(wr_addr) <= shelf_count_reg))
        else $error("shelf table write beyond count");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for shelf_rect_packer: random and directed placement
// requests, checked against a shelf packing predictor kept inside this file.
// Depends on srp_pkg and the shelf_rect_packer RTL.
`timescale 1ns / 1ps

module tb_top;
    import srp_pkg::*;

    localparam int unsigned RUN_LIMIT      = 400000;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned END_CYCLES     = 80;

    // One predicted placement result
    typedef struct {
        srp_status_t          status;
        logic [SRP_POS_W-1:0] pos_x;
        logic [SRP_POS_W-1:0] pos_y;
    } placement_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // rect_width[12:0], rect_height[25:13]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;         // status[1:0], pos_x[13:2], pos_y[25:14]
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = SRP_REG_ATLAS_WIDTH;
    logic [SRP_DIM_W-1:0] cfg_wdata = '0;

    // Requests waiting to be driven and placements waiting to be seen
    logic [25:0]  rect_q[$];
    placement_t   placement_q[$];

    int unsigned  send_idle_pct = 6;
    int unsigned  recv_idle_pct = 84;
    logic         req_fire      = 1'b0;
    logic         hold_req      = 1'b0;
    logic         rx_hold       = 1'b0;
    int unsigned  n_pushed      = 0;
    int unsigned  n_done        = 0;
    int unsigned  err_cnt       = 0;
    int unsigned  cycles        = 0;
    int unsigned  n_placed      = 0;
    int unsigned  n_height_full = 0;
    int unsigned  n_table_full  = 0;

    // Predictor copy of the atlas size and the shelf table
    int unsigned  atlas_w = SRP_ATLAS_RESET;
    int unsigned  atlas_h = SRP_ATLAS_RESET;
    int unsigned  shelf_x[SRP_MAX_SHELVES];
    int unsigned  shelf_y[SRP_MAX_SHELVES];
    int unsigned  shelf_h[SRP_MAX_SHELVES];
    int unsigned  shelf_cnt = 0;

    shelf_rect_packer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // First-fit shelf placement of one padded rectangle; updates the shelf table.
    function automatic placement_t place_rect(input logic [SRP_DIM_W-1:0] w,
                                              input logic [SRP_DIM_W-1:0] h);
        int unsigned pw;
        int unsigned ph;
        int unsigned new_y;
        placement_t  r;
        pw       = w + SRP_PAD;
        ph       = h + SRP_PAD;
        r.status = SRP_ST_PLACED;
        r.pos_x  = '0;
        r.pos_y  = '0;
        for (int i = 0; i < shelf_cnt; i++) begin
            if (shelf_x[i] + pw <= atlas_w && ph <= shelf_h[i]) begin
                r.pos_x    = shelf_x[i][SRP_POS_W-1:0];
                r.pos_y    = shelf_y[i][SRP_POS_W-1:0];
                shelf_x[i] = shelf_x[i] + pw;
                return r;
            end
        end
        // No shelf fits: open one below the last, height check first
        new_y = 0;
        if (shelf_cnt > 0)
            new_y = shelf_y[shelf_cnt-1] + shelf_h[shelf_cnt-1];
        if (new_y + ph > atlas_h) begin
            r.status = SRP_ST_HEIGHT_FULL;
        end else if (shelf_cnt >= SRP_MAX_SHELVES) begin
            r.status = SRP_ST_TABLE_FULL;
        end else begin
            shelf_x[shelf_cnt] = pw;
            shelf_y[shelf_cnt] = new_y;
            shelf_h[shelf_cnt] = ph;
            shelf_cnt++;
            r.pos_y = new_y[SRP_POS_W-1:0];
        end
        return r;
    endfunction

    // Request driver: holds tvalid until the transfer, then offers the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (rect_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, rect_q.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with random stalls and the long hold-off.
    always @(negedge aclk) begin
        if (!aresetn || rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin
        wait (hold_req);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Monitor: tracks register writes, predicts each accepted request and
    // checks each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        placement_t exp_r;
        if (!aresetn) begin
            req_fire  <= 1'b0;
            atlas_w   = SRP_ATLAS_RESET;
            atlas_h   = SRP_ATLAS_RESET;
            shelf_cnt = 0;
        end else begin
            req_fire <= s_tvalid && s_tready;
            if (cfg_wr_en) begin
                if (cfg_index == SRP_REG_ATLAS_WIDTH)
                    atlas_w = cfg_wdata;
                else
                    atlas_h = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                exp_r = place_rect(s_tdata[12:0], s_tdata[25:13]);
                case (exp_r.status)
                    SRP_ST_PLACED:      n_placed++;
                    SRP_ST_HEIGHT_FULL: n_height_full++;
                    default:            n_table_full++;
                endcase
                placement_q.insert(placement_q.size(), exp_r);
            end
            if (m_tvalid && m_tready) begin
                n_done++;
                if (placement_q.size() == 0) begin
                    $error("result transfer with no request waiting: tdata %h", m_tdata);
                    err_cnt++;
                end else begin
                    exp_r = placement_q.pop_front();
                    if (m_tdata[1:0] !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[13:2] !== exp_r.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", exp_r.pos_x, m_tdata[13:2]);
                        err_cnt++;
                    end
                    if (m_tdata[25:14] !== exp_r.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", exp_r.pos_y, m_tdata[25:14]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("tb_top: run limit reached with %0d results outstanding",
                     n_pushed - n_done);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic queue_rect(input int unsigned w, input int unsigned h);
        rect_q.insert(rect_q.size(), {h[12:0], w[12:0]});
        n_pushed++;
    endtask

    // Wait until every queued request has produced its result.
    task automatic drain();
        do @(negedge aclk); while (n_done != n_pushed);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= val[SRP_DIM_W-1:0];
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_atlas(input int unsigned w, input int unsigned h);
        drain();
        write_reg(SRP_REG_ATLAS_WIDTH, w);
        write_reg(SRP_REG_ATLAS_HEIGHT, h);
        @(posedge aclk);
    endtask

    // Random request mix: small rectangles that pack onto shelves, wide ones that
    // force new shelves, medium ones and a share of the full field range.
    task automatic queue_random(input int unsigned n);
        int unsigned pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_rect($urandom_range(60), $urandom_range(24));
            else if (pick < 65)
                queue_rect($urandom_range(8191, 500), $urandom_range(12));
            else if (pick < 85)
                queue_rect($urandom_range(1000), $urandom_range(120));
            else
                queue_rect($urandom_range(8191), $urandom_range(8191));
        end
    endtask

    task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                             input int unsigned w, input int unsigned h,
                             input int unsigned n);
        set_atlas(w, h);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queue_random(n);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Zero-sized atlas: nothing can be placed
        set_atlas(0, 0);
        queue_rect(1, 1);
        queue_rect(0, 0);
        // One-pixel atlas: padding alone overflows the height
        set_atlas(1, 1);
        queue_rect(0, 0);
        queue_rect(8191, 0);
        // Wide, tall atlas: new shelves, refits, shelves past the width,
        // height overflow and rows below y = 4096
        set_atlas(4096, 8191);
        queue_rect(0, 0);
        queue_rect(1, 1);
        queue_rect(0, 0);
        queue_rect(4096, 4096);
        queue_rect(8191, 8191);
        queue_rect(4094, 0);
        queue_rect(4093, 0);
        queue_rect(2, 0);
        queue_rect(1234, 5678);
        queue_rect(100, 4000);
        queue_rect(0, 4095);
        queue_rect(4096, 1);

        run_phase(6, 84, 512, 8191, 160);
        run_phase(84, 6, 4096, 4096, 160);

        // Receiver holds off while requests keep coming
        set_atlas(8191, 8191);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        queue_random(60);

        run_phase(0, 0, 1000, 6000, 120);

        drain();
        repeat (END_CYCLES) @(posedge aclk);
        if (placement_q.size() != 0) begin
            $error("%0d predicted placements never arrived", placement_q.size());
            err_cnt++;
        end
        $display("tb_top: %0d requests over seven atlas settings, %0d shelves opened",
                 n_pushed, shelf_cnt);
        $display("tb_top: %0d placed, %0d out of atlas height, %0d with shelf table full",
                 n_placed, n_height_full, n_table_full);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[shelf_rect_packer.f]
sv/srp_pkg.sv
sv/srp_fit_unit.sv
sv/shelf_rect_packer.sv
tb/tb_top.sv
